/* rtl/core/mfcc_pkg.sv */
// ----------------------------------------------------------------------------
// mfcc_pkg
// Shared constants, status codes and the CRC-16/MODBUS byte fold.
// ----------------------------------------------------------------------------
package mfcc_pkg;

    // Hard ceiling on bytes taken into one frame (5 .. 511 with LEN_W = 9)
    localparam int MAX_FRAME = 256;

    localparam int LEN_W    = 9;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [LEN_W-1:0] MIN_FRAME = 9'd5;
    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 9'd256;

    // Register indexes
    localparam logic REG_MAX_LENGTH = 1'b0;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TOO_SHORT = 2'd1,
        STATUS_CRC_ERR   = 2'd2
    } status_t;

    // One byte into the reflected CRC, LSB first
    function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
                                             input logic [7:0]  data_in);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data_in};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* rtl/core/mfcc_apb_regs.sv */
// ----------------------------------------------------------------------------
// mfcc_apb_regs
// APB register file: holds the max_length register.
// ----------------------------------------------------------------------------
module mfcc_apb_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mfcc_pkg::CFG_AW-1:0]    paddr,
    input  logic [mfcc_pkg::CFG_DW-1:0]    pwdata,
    output logic [mfcc_pkg::CFG_DW-1:0]    prdata,
    output logic                           pready,
    output logic [mfcc_pkg::LEN_W-1:0]     max_length
);
    import mfcc_pkg::*;

    logic [LEN_W-1:0] max_length_reg;
    logic             wr_en;

    // Word index is paddr[2]; byte offset bits ignored
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg <= MAX_LENGTH_RESET;
        end else if (wr_en && (paddr[2] == REG_MAX_LENGTH)) begin
            max_length_reg <= pwdata[LEN_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MAX_LENGTH) begin
            prdata = {{(CFG_DW-LEN_W){1'b0}}, max_length_reg};
        end
    end

    assign max_length = max_length_reg;

endmodule

/* rtl/core/modbus_frame_crc_checker.sv */
// ----------------------------------------------------------------------------
// modbus_frame_crc_checker
// Byte-wise Modbus RTU frame checker with CRC-16/MODBUS and length status.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream (s_*): one transaction per received item. s_tdata holds the
//    byte, s_tuser flags that the byte is present, s_tlast ends the frame
//    after this item's byte (an item with only s_tlast set ends the frame
//    without adding a byte).
//  - Output stream (m_*): one transaction per frame end. m_tuser is the
//    status (ok / too short / CRC mismatch), m_tdata the frame length
//    including the two CRC bytes.
//  - APB port: register 0 (byte address 0) is max_length; bytes beyond
//    min(max_length, MAX_FRAME) are dropped.
//  - Path: an input transaction goes through the input register, then CRC fold
//    and compare into the result register, which drives m_tvalid.
//  - Throughput: one item per cycle while no frame-end item is stalled; the 8-bit CRC fold is fully unrolled in
//    the single logic stage.
//  - Stall: a frame-end item waits in the input register while a result is
//    still pending on m_*; s_tready drops only then. Other items flow on.
//  - Reset: synchronous active-low; CRC to 0xFFFF, counters and held bytes
//    cleared, max_length to 256, no result pending.
// ----------------------------------------------------------------------------
module modbus_frame_crc_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] byte_value
    input  logic                           s_tuser,   // [0] has_byte
    input  logic                           s_tlast,   // frame_end
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,   // [8:0] frame_length, rest 0
    output logic [1:0]                     m_tuser,   // [1:0] status
    // APB configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mfcc_pkg::CFG_AW-1:0]    paddr,
    input  logic [mfcc_pkg::CFG_DW-1:0]    pwdata,
    output logic [mfcc_pkg::CFG_DW-1:0]    prdata,
    output logic                           pready
);
    import mfcc_pkg::*;

    // ---------------------------------------------------------------- config
    logic [LEN_W-1:0] max_length;
    logic [LEN_W-1:0] limit;

    mfcc_apb_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .max_length (max_length)
    );

    // Effective limit is the smaller of the register and the hard ceiling
    always_comb begin
        if (int'(max_length) > MAX_FRAME) begin
            limit = LEN_W'(MAX_FRAME);
        end else begin
            limit = max_length;
        end
    end

    // --------------------------------------------------------- input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_has_byte_reg;
    logic       in_end_reg;
    logic       advance;      // input register item is consumed this cycle

    // Only frame-end items need space in the result register
    assign advance  = in_valid_reg && (!in_end_reg || !m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg     <= s_tdata;
            in_has_byte_reg <= s_tuser;
            in_end_reg      <= s_tlast;
        end
    end

    // ------------------------------------------------------------ frame state
    logic [15:0]      crc_reg,    crc_next;
    logic [LEN_W-1:0] count_reg,  count_next;
    logic [7:0]       older_reg,  older_next;
    logic [7:0]       newer_reg,  newer_next;

    logic [15:0]      crc_upd;
    logic [LEN_W-1:0] count_upd;
    logic [7:0]       older_upd;
    logic [7:0]       newer_upd;
    logic             take;
    status_t          status_calc;

    // Last two taken bytes are held back as the received CRC; the older one
    // is folded in only once a newer byte displaces it.
    assign take = in_has_byte_reg && (count_reg < limit);

    always_comb begin
        crc_upd   = crc_reg;
        count_upd = count_reg;
        older_upd = older_reg;
        newer_upd = newer_reg;
        if (take) begin
            if (count_reg >= LEN_W'(2)) begin
                crc_upd = crc_fold(crc_reg, older_reg);
            end
            older_upd = newer_reg;
            newer_upd = in_byte_reg;
            count_upd = count_reg + LEN_W'(1);
        end
    end

    always_comb begin
        if (count_upd < MIN_FRAME) begin
            status_calc = STATUS_TOO_SHORT;
        end else if ({newer_upd, older_upd} == crc_upd) begin
            status_calc = STATUS_OK;
        end else begin
            status_calc = STATUS_CRC_ERR;
        end
    end

    always_comb begin
        crc_next   = crc_reg;
        count_next = count_reg;
        older_next = older_reg;
        newer_next = newer_reg;
        if (advance) begin
            if (in_end_reg) begin
                crc_next   = CRC_INIT;
                count_next = '0;
                older_next = '0;
                newer_next = '0;
            end else begin
                crc_next   = crc_upd;
                count_next = count_upd;
                older_next = older_upd;
                newer_next = newer_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= CRC_INIT;
            count_reg <= '0;
            older_reg <= '0;
            newer_reg <= '0;
        end else begin
            crc_reg   <= crc_next;
            count_reg <= count_next;
            older_reg <= older_next;
            newer_reg <= newer_next;
        end
    end

    // -------------------------------------------------------- result register
    logic             out_valid_reg;
    status_t          out_status_reg;
    logic [LEN_W-1:0] out_len_reg;
    logic             load_result;

    assign load_result = advance && in_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_result) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_result) begin
            out_status_reg <= status_calc;
            out_len_reg    <= count_upd;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(16-LEN_W){1'b0}}, out_len_reg};

    // ------------------------------------------------------------ assertions
    // Input side stalls only behind an undelivered result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (out_valid_reg && !m_tready && in_end_reg))
        else $error("input stalled without a pending result");

    // Frame end always leaves a clean frame state behind
    a_clear_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        load_result |=> (count_reg == '0 && crc_reg == CRC_INIT))
        else $error("frame state not cleared after frame end");

    // Count never passes the hard ceiling
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(count_reg) <= MAX_FRAME)
        else $error("byte count beyond MAX_FRAME");

    // A too-short status goes with a length under the minimum
    a_short_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_status_reg == STATUS_TOO_SHORT) |-> (out_len_reg < MIN_FRAME))
        else $error("too-short status with a full-length frame");

endmodule
